FILE: sv/lphs_pkg.sv
package lphs_pkg;
    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = 11;
    localparam int KEY_W = 64;
    // memory word: valid, key, home
    localparam int ENT_W = 1 + KEY_W + IDX_W;

    localparam logic [1:0] OP_CONTAINS = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    // datapath commands
    localparam logic [2:0] DC_NONE   = 3'd0;
    localparam logic [2:0] DC_RDPTR  = 3'd1;  // read slot at probe pointer
    localparam logic [2:0] DC_INS    = 3'd2;  // write new key at probe pointer
    localparam logic [2:0] DC_SHIFT  = 3'd3;  // copy scan slot into hole
    localparam logic [2:0] DC_KILL   = 3'd4;  // clear valid of hole
    localparam logic [2:0] DC_RDSCAN = 3'd5;  // read slot at scan pointer
    localparam logic [2:0] DC_WIPE   = 3'd6;  // empty slot at probe pointer

    typedef struct packed {
        logic             hash_start;
        logic             load_home;
        logic [2:0]       cmd;
        logic             ptr_step;
        logic             hole_set;
        logic             scan_step;
        logic             clear_all;
        logic             cnt_inc;
        logic             cnt_dec;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic stays;
        logic half_full;
        logic cnt_nz;
        logic wipe_last;
    } t_dp_sts;
endpackage

FILE: sv/lphs_if.sv
interface lphs_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/lphs_ram.sv
module lphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/lphs_hash.sv
module lphs_hash import lphs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_done,
    output logic [IDX_W-1:0] o_home
);
    // 64x64 products cut into 32x32 partial products, one per cycle
    logic [63:0] r_h;
    logic [63:0] r_acc;
    logic [2:0]  r_step;
    logic        r_busy;
    logic [63:0] n_h;
    logic [63:0] n_acc;
    logic [63:0] w_c;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_p;

    assign w_c = (r_step < 3'd3) ? MIX_C1 : MIX_C2;
    always_comb begin
        unique case (r_step)
            3'd0, 3'd3: begin w_a = r_h[31:0];  w_b = w_c[31:0];  end
            3'd1, 3'd4: begin w_a = r_h[31:0];  w_b = w_c[63:32]; end
            default:    begin w_a = r_h[63:32]; w_b = w_c[31:0];  end
        endcase
    end
    assign w_p = {32'd0, w_a} * {32'd0, w_b};

    always_comb begin
        n_h   = r_h;
        n_acc = r_acc;
        unique case (r_step)
            3'd0, 3'd3: n_acc = w_p;
            3'd1, 3'd4: n_acc = r_acc + {w_p[31:0], 32'd0};
            default: begin
                n_acc = r_acc + {w_p[31:0], 32'd0};
                n_h   = n_acc ^ (n_acc >> 33);
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            r_step <= (r_step == 3'd5) ? 3'd0 : r_step + 3'd1;
            if (r_step == 3'd5) r_busy <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= i_key ^ (i_key >> 33);
        end else if (r_busy) begin
            r_h   <= n_h;
            r_acc <= n_acc;
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_home = r_h[IDX_W-1:0];
endmodule

FILE: sv/lphs_dp.sv
module lphs_dp import lphs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [KEY_W-1:0] i_key,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic [CNT_W-1:0] o_count
);
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_hole;
    logic [IDX_W-1:0] r_home;
    logic [CNT_W-1:0] r_count;
    logic [ENT_W-1:0] w_rdata;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_ehome;
    logic [IDX_W-1:0] w_hash_home;
    logic             w_hash_done;

    lphs_hash u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.hash_start),
        .i_key  (i_key),
        .o_done (w_hash_done),
        .o_home (w_hash_home)
    );

    // valid, key and home share one memory word
    assign w_raddr = r_ptr;
    assign w_we    = (i_cmd.cmd == DC_INS) || (i_cmd.cmd == DC_SHIFT) ||
                     (i_cmd.cmd == DC_KILL) || (i_cmd.cmd == DC_WIPE);
    assign w_waddr = ((i_cmd.cmd == DC_SHIFT) || (i_cmd.cmd == DC_KILL)) ? r_hole : r_ptr;
    assign w_wdata = (i_cmd.cmd == DC_INS)   ? {1'b1, r_key, r_home} :
                     (i_cmd.cmd == DC_SHIFT) ? w_rdata : '0;

    lphs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_ehome = w_rdata[IDX_W-1:0];

    // probe and hole pointers; pointer starts at slot 0 for the clearing pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_start) r_key <= i_key;
        if (i_cmd.load_home) r_home <= w_hash_home;
        if (!i_rst_n || i_cmd.clear_all) begin
            r_ptr <= '0;
        end else if (i_cmd.load_home) begin
            r_ptr <= w_hash_home;
        end else if (i_cmd.ptr_step || i_cmd.scan_step) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (i_cmd.hole_set) r_hole <= r_ptr;
        else if (i_cmd.cmd == DC_SHIFT) r_hole <= r_ptr;
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_count <= '0;
        end else begin
            if (i_cmd.cnt_inc) r_count <= r_count + CNT_W'(1);
            else if (i_cmd.cnt_dec) r_count <= r_count - CNT_W'(1);
        end
    end

    // status; r_ptr here is the scanned slot j, r_hole is i
    always_comb begin
        o_sts.hash_done  = w_hash_done;
        o_sts.slot_valid = w_rdata[ENT_W-1];
        o_sts.key_match  = (w_rdata[ENT_W-2:IDX_W] == r_key);
        if (r_hole <= r_ptr) o_sts.stays = (r_hole < w_ehome) && (w_ehome <= r_ptr);
        else o_sts.stays = (r_hole < w_ehome) || (w_ehome <= r_ptr);
        o_sts.half_full = ({r_count, 1'b0} >= (CNT_W + 1)'(SLOTS));
        o_sts.cnt_nz    = (r_count != '0);
        o_sts.wipe_last = (r_ptr == IDX_W'(SLOTS - 1));
    end

    assign o_count = r_count;
endmodule

FILE: sv/lphs_ctrl.sv
module lphs_ctrl import lphs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic       o_present,
    output logic       o_status,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SCHK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_WIPE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_op;
    logic       r_present;
    logic       r_status;
    logic       n_present;
    logic       n_status;
    logic       w_acc;

    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_present   = r_present;
    assign o_status    = r_status;

    always_comb begin
        n_state   = r_state;
        n_present = r_present;
        n_status  = r_status;
        o_cmd     = '0;
        o_cmd.cmd = DC_NONE;
        unique case (r_state)
            S_IDLE, S_OUT: begin
                if (r_state == S_OUT && i_out_ready) n_state = S_IDLE;
                if (w_acc) begin
                    n_present = 1'b0;
                    n_status  = 1'b0;
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clear_all = 1'b1;
                        n_state = S_WIPE;
                    end else begin
                        o_cmd.hash_start = 1'b1;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: if (i_sts.hash_done) begin
                o_cmd.load_home = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.cmd = DC_RDPTR;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.slot_valid && !i_sts.key_match) begin
                    o_cmd.ptr_step = 1'b1;
                    n_state = S_RD;
                end else if (i_sts.slot_valid) begin
                    n_present = 1'b1;
                    if (r_op == OP_REMOVE) begin
                        o_cmd.hole_set  = 1'b1;
                        o_cmd.scan_step = 1'b1;
                        o_cmd.cnt_dec   = i_sts.cnt_nz;
                        n_state = S_SRD;
                    end else n_state = S_OUT;
                end else begin
                    if (r_op == OP_ADD) begin
                        if (i_sts.half_full) n_status = 1'b1;
                        else begin
                            o_cmd.cmd     = DC_INS;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    n_state = S_OUT;
                end
            end
            S_SRD: begin
                o_cmd.cmd = DC_RDSCAN;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (!i_sts.slot_valid) begin
                    o_cmd.cmd = DC_KILL;
                    n_state = S_OUT;
                end else if (i_sts.stays) begin
                    o_cmd.scan_step = 1'b1;
                    n_state = S_SRD;
                end else begin
                    o_cmd.cmd = DC_SHIFT;
                    o_cmd.scan_step = 1'b1;
                    n_state = S_SRD;
                end
            end
            // clearing pass over every slot, after reset and for a clear word
            S_WIPE: begin
                o_cmd.cmd      = DC_WIPE;
                o_cmd.ptr_step = 1'b1;
                if (i_sts.wipe_last) n_state = (r_op == OP_CLEAR) ? S_OUT : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_op    <= OP_CONTAINS;
        end else begin
            r_state <= n_state;
            if (w_acc) r_op <= i_op;
        end
        r_present <= n_present;
        r_status  <= n_status;
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_present)))
        else $error("result changed while stalled");
    a_no_refuse_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(r_present && r_status))
        else $error("refused add on present key");
    a_ins_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cmd == DC_INS) |-> !i_sts.half_full)
        else $error("insert beyond half load");
    a_wipe_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIPE) |-> !o_in_ready)
        else $error("word accepted during clearing pass");
`endif
endmodule

FILE: sv/linear_probe_hash_set_core.sv
// hash and home load (six 32x32 partial products), then a read and a check per probed slot
// remove adds a scan read and check per slot scanned after the freed slot for backward shift
// clear runs a pass over all 1024 slots before its result is offered
// one word at a time: next word accepted as the result is taken
// synchronous active-low reset, then a clearing pass over all slots with input not ready
module linear_probe_hash_set_core import lphs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lphs_if.sink   i_req,
    lphs_if.source o_rsp
);
    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [CNT_W-1:0] w_count;
    logic             w_present;
    logic             w_status;

    lphs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_op       (i_req.data[KEY_W+1:KEY_W]),
        .o_in_ready (i_req.ready),
        .i_out_ready(o_rsp.ready),
        .o_out_valid(o_rsp.valid),
        .o_present  (w_present),
        .o_status   (w_status),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lphs_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_key  (i_req.data[KEY_W-1:0]),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_count(w_count)
    );

    // result word: present, status, entry_count
    assign o_rsp.data = {w_present, w_status, w_count};
endmodule

FILE: tb/sv/linear_probe_hash_set_core_tb.sv
module linear_probe_hash_set_core_tb;
    import lphs_pkg::*;

    localparam int REQ_W = 2 + KEY_W;
    localparam int RSP_W = 2 + CNT_W;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic             present;
        logic             status;
        logic [CNT_W-1:0] entry_count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lphs_if #(REQ_W) req_ch ();
    lphs_if #(RSP_W) rsp_ch ();

    linear_probe_hash_set_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the set
    bit              shadow_valid [SLOTS];
    logic [KEY_W-1:0] shadow_key  [SLOTS];
    logic [IDX_W-1:0] shadow_home [SLOTS];
    int unsigned     shadow_count;

    t_answer         pending_answers[$];
    int unsigned     fail_count;
    bit              steady_flow;
    logic [KEY_W-1:0] key_pool[$];

    function automatic logic [IDX_W-1:0] murmur_home(input logic [KEY_W-1:0] key);
        logic [63:0] h;
        h = key;
        h = h ^ (h >> 33);
        h = h * MIX_C1;
        h = h ^ (h >> 33);
        h = h * MIX_C2;
        h = h ^ (h >> 33);
        return h[IDX_W-1:0];
    endfunction

    function automatic int step_idx(input int i);
        return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    // backward-shift deletion starting at the freed slot
    function automatic void shift_out(input int hole);
        int j;
        int k;
        bit stays;
        j = hole;
        shadow_valid[hole] = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            j = step_idx(j);
            if (!shadow_valid[j]) break;
            k = int'(shadow_home[j]);
            if (hole <= j) stays = (hole < k) && (k <= j);
            else stays = (hole < k) || (k <= j);
            if (stays) continue;
            shadow_valid[hole] = 1'b1;
            shadow_key[hole] = shadow_key[j];
            shadow_home[hole] = shadow_home[j];
            shadow_valid[j] = 1'b0;
            hole = j;
        end
    endfunction

    function automatic t_answer apply_to_set(input logic [1:0] op, input logic [KEY_W-1:0] key);
        t_answer ans;
        int home;
        int s;
        bit found;
        ans = '0;
        if (op == OP_CLEAR) begin
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
            shadow_count = 0;
        end else begin
            home = int'(murmur_home(key));
            s = home;
            for (int n = 0; n < SLOTS; n++) begin
                if (!shadow_valid[s] || shadow_key[s] == key) break;
                s = step_idx(s);
            end
            found = shadow_valid[s] && (shadow_key[s] == key);
            ans.present = found;
            if (op == OP_ADD && !found) begin
                if (2 * shadow_count >= SLOTS || shadow_valid[s]) begin
                    ans.status = 1'b1;
                end else begin
                    shadow_valid[s] = 1'b1;
                    shadow_key[s] = key;
                    shadow_home[s] = IDX_W'(home);
                    shadow_count++;
                end
            end else if (op == OP_REMOVE && found) begin
                shift_out(s);
                if (shadow_count > 0) shadow_count--;
            end
        end
        ans.entry_count = shadow_count[CNT_W-1:0];
        return ans;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // send one word and predict its result on acceptance
    task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = {op, key};
        do @(posedge i_clk); while (!req_ch.ready);
        pending_answers.push_back(apply_to_set(op, key));
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(negedge i_clk);
    endtask

    // result side stalls
    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_answers.size() == 0) begin
                $error("unexpected result word %h", got);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.present !== want.present) begin
                    $error("present: expected %0d actual %0d", want.present, got.present);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d actual %0d",
                           want.entry_count, got.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("linear_probe_hash_set_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_set();
        send_word(OP_CONTAINS, 64'd0);
        send_word(OP_REMOVE, 64'd0);
        send_word(OP_CONTAINS, '1);
    endtask

    // key extremes, duplicate add, remove present and absent
    task automatic test_key_extremes();
        send_word(OP_ADD, 64'd0);
        send_word(OP_ADD, '1);
        send_word(OP_ADD, 64'h8000_0000_0000_0000);
        send_word(OP_ADD, 64'd0);
        send_word(OP_CONTAINS, '1);
        send_word(OP_CONTAINS, 64'd1);
        send_word(OP_REMOVE, '1);
        send_word(OP_CONTAINS, '1);
        send_word(OP_REMOVE, '1);
        send_word(OP_CONTAINS, 64'd0);
        send_word(OP_ADD, 64'h5555_5555_5555_5555);
        send_word(OP_ADD, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    task automatic test_clear();
        send_word(OP_CLEAR, 64'($urandom()));
        send_word(OP_CONTAINS, 64'd0);
        send_word(OP_CLEAR, '1);
    endtask

    // fill to half load, see refusal, remove some keys, then clear
    task automatic test_half_full_refusal();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] held[$];
        steady_flow = 1'b1;
        while (shadow_count < SLOTS / 2) begin
            k = {$urandom(), $urandom()};
            held.push_back(k);
            send_word(OP_ADD, k);
        end
        steady_flow = 1'b0;
        send_word(OP_ADD, {$urandom(), $urandom()});
        send_word(OP_ADD, held[0]);
        send_word(OP_CONTAINS, held[$]);
        // removals in a dense table exercise long shifts
        for (int i = 0; i < 60; i++) send_word(OP_REMOVE, held[$urandom_range(held.size() - 1)]);
        for (int i = 0; i < 20; i++) send_word(OP_CONTAINS, held[$urandom_range(held.size() - 1)]);
        send_word(OP_CLEAR, 64'd0);
    endtask

    task automatic test_drain_pause();
        send_word(OP_ADD, 64'd77);
        wait_drained();
        send_word(OP_CONTAINS, 64'd77);
        send_word(OP_REMOVE, 64'd77);
    endtask

    // random mix over a reused key pool so keys come back
    task automatic test_random_mix(input int n_words);
        int r;
        logic [1:0] op;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 300; i++) key_pool.push_back({$urandom(), $urandom()});
        for (int i = 0; i < n_words; i++) begin
            steady_flow = (i % 200) >= 170;
            r = $urandom_range(999);
            if (r < 5) op = OP_CLEAR;
            else if (r < 450) op = OP_ADD;
            else if (r < 750) op = OP_REMOVE;
            else op = OP_CONTAINS;
            if ($urandom_range(99) < 80) k = key_pool[$urandom_range(key_pool.size() - 1)];
            else k = {$urandom(), $urandom()};
            send_word(op, k);
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        fail_count = 0;
        steady_flow = 1'b0;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        shadow_count = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_set();
        test_key_extremes();
        test_clear();
        test_drain_pause();
        test_half_full_refusal();
        test_random_mix(200);

        wait_drained();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("linear_probe_hash_set_core: match");
        end else begin
            $display("linear_probe_hash_set_core: mismatch");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/lphs_pkg.sv
sv/lphs_if.sv
sv/lphs_ram.sv
sv/lphs_hash.sv
sv/lphs_dp.sv
sv/lphs_ctrl.sv
sv/linear_probe_hash_set_core.sv
tb/sv/linear_probe_hash_set_core_tb.sv
